@@ rtl/tkst_pkg.sv @@
`default_nettype none

package tkst_pkg;

  localparam int unsigned MAX_KEPT = 16;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned RANK_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned LEN_W    = $clog2(MAX_KEPT + 1);
  localparam int unsigned IDX_W    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DUMP   = 1'b1
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  typedef struct packed {
    op_e                       opcode;
    logic [DATA_W-1:0]         cand_seed;
    logic signed [DATA_W-1:0]  cand_score;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]         rank;
    logic [DATA_W-1:0]         out_seed;
    logic signed [DATA_W-1:0]  out_score;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic do_insert;
    logic dump_start;
    logic dump_next;
  } cmd_t;

  typedef struct packed {
    logic list_empty;
    logic at_last;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/top_k_score_tracker.sv @@
// Insert: an insert transaction is taken every cycle while no dump runs.
// Dump of n active entries: n output transactions, the first shown the cycle after
// the dump is accepted, then one per cycle as the sink takes them; input held off
// meanwhile. A dump with an empty list produces nothing.
// Reset (async, active low): list cleared to zero score and seed, length 1.
`default_nettype none

module top_k_score_tracker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [tkst_pkg::CFG_W-1:0]  cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire tkst_pkg::in_item_t          in_item_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output tkst_pkg::out_item_t              out_item_o
);
  import tkst_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  tkst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (in_item_i.opcode),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tkst_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

@@ rtl/tkst_ctrl.sv @@
`default_nettype none

module tkst_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire tkst_pkg::op_e    opcode_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire tkst_pkg::status_t status_i,
  output tkst_pkg::cmd_t        cmd_o
);
  import tkst_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        // an empty list dumps nothing, so stay put
        if (in_valid_i && opcode_i == OP_DUMP && !status_i.list_empty) begin
          state_d = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (out_ready_i && status_i.at_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    out_valid_o      = 1'b0;
    cmd_o            = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.do_insert  = in_valid_i && opcode_i == OP_INSERT;
        cmd_o.dump_start = in_valid_i && opcode_i == OP_DUMP;
      end
      ST_DUMP: begin
        out_valid_o     = 1'b1;
        cmd_o.dump_next = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/tkst_datapath.sv @@
`default_nettype none

module tkst_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [tkst_pkg::CFG_W-1:0]   cfg_data_i,
  input  wire tkst_pkg::in_item_t           in_item_i,
  input  wire tkst_pkg::cmd_t               cmd_i,
  output tkst_pkg::status_t                 status_o,
  output tkst_pkg::out_item_t               out_item_o
);
  import tkst_pkg::*;

  logic [CFG_W-1:0]         len_q;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic signed [DATA_W-1:0] score_q [MAX_KEPT];
  logic [DATA_W-1:0]        seed_q  [MAX_KEPT];
  logic signed [DATA_W-1:0] score_d [MAX_KEPT];
  logic [DATA_W-1:0]        seed_d  [MAX_KEPT];

  logic [LEN_W-1:0]    n_act;
  logic [MAX_KEPT-1:0] active;
  logic [MAX_KEPT-1:0] gt;
  logic [MAX_KEPT-1:0] none_from;
  logic [LEN_W-1:0]    idx_next;

  // lengths above the storage depth clamp to it
  always_comb begin
    if (32'(len_q) > 32'(MAX_KEPT)) begin
      n_act = LEN_W'(MAX_KEPT);
    end else begin
      n_act = LEN_W'(len_q);
    end
  end

  // per entry: strictly better than the candidate, within the active list
  always_comb begin
    for (int k = 0; k < MAX_KEPT; k++) begin
      active[k] = LEN_W'(k) < n_act;
      gt[k]     = active[k] && (score_q[k] > in_item_i.cand_score);
    end
    for (int k = 0; k < MAX_KEPT; k++) begin
      none_from[k] = ~|(gt >> k);
    end
  end

  // entries at or past the insert point shift down; the one at it takes the candidate
  always_comb begin
    for (int k = 0; k < MAX_KEPT; k++) begin
      score_d[k] = score_q[k];
      seed_d[k]  = seed_q[k];
      if (cmd_i.do_insert && active[k] && none_from[k]) begin
        if (k == 0) begin
          score_d[k] = in_item_i.cand_score;
          seed_d[k]  = in_item_i.cand_seed;
        end else if (gt[(k == 0) ? 0 : k-1]) begin
          score_d[k] = in_item_i.cand_score;
          seed_d[k]  = in_item_i.cand_seed;
        end else begin
          score_d[k] = score_q[(k == 0) ? 0 : k-1];
          seed_d[k]  = seed_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_KEPT; k++) begin
        score_q[k] <= '0;
        seed_q[k]  <= '0;
      end
    end else begin
      for (int k = 0; k < MAX_KEPT; k++) begin
        score_q[k] <= score_d[k];
        seed_q[k]  <= seed_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= CFG_W'(1);
    end else if (cfg_valid_i) begin
      len_q <= cfg_data_i;
    end
  end

  assign idx_next = LEN_W'(idx_q) + LEN_W'(1);

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.dump_start) begin
      idx_d = '0;
    end else if (cmd_i.dump_next) begin
      idx_d = IDX_W'(idx_next);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  assign status_o.list_empty = n_act == '0;
  assign status_o.at_last    = idx_next == n_act;

  assign out_item_o.rank      = RANK_W'(idx_q);
  assign out_item_o.out_seed  = seed_q[idx_q];
  assign out_item_o.out_score = score_q[idx_q];
  assign out_item_o.last      = idx_next == n_act;

endmodule

`default_nettype wire

@@ rtl/tkst_checker.sv @@
`default_nettype none

module tkst_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_o,
  input  wire tkst_pkg::in_item_t  in_item_i,
  input  wire logic                out_valid_o,
  input  wire logic                out_ready_i,
  input  wire tkst_pkg::out_item_t out_item_o
);
  import tkst_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // no new transaction taken while a dump is being delivered
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready during dump");

  // a dump runs on to its last entry with ranks in sequence
  a_rank_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_item_o.last |=>
      out_valid_o && out_item_o.rank == $past(out_item_o.rank) + RANK_W'(1))
    else $error("dump broke off or skipped a rank");

  // an insert gives no result
  a_insert_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.opcode == OP_INSERT |=> !out_valid_o)
    else $error("result after insert");

endmodule

bind top_k_score_tracker tkst_checker u_tkst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

@@ bench/top_k_score_tracker_test.sv @@
`timescale 1ns / 100ps

module top_k_score_tracker_test;
  import tkst_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES = 4;

  // Mirror of the kept list plus the queue of dump entries still to come out.
  class ranked_list_model;
    logic signed [DATA_W-1:0] kept_score[MAX_KEPT];
    logic [DATA_W-1:0]        kept_seed[MAX_KEPT];
    logic [CFG_W-1:0]         length;
    out_item_t                due_entries[$];
    int unsigned              errors;
    int unsigned              inserts;
    int unsigned              dumps;
    int unsigned              entries_checked;
    int unsigned              settings;

    function new();
      for (int k = 0; k < MAX_KEPT; k++) begin
        kept_score[k] = '0;
        kept_seed[k]  = '0;
      end
      length = 1;
      errors = 0;
      inserts = 0;
      dumps = 0;
      entries_checked = 0;
      settings = 0;
    endfunction

    function void set_length(logic [CFG_W-1:0] v);
      length = v;
      settings++;
    endfunction

    function int pending();
      return due_entries.size();
    endfunction

    function void note_input(in_item_t it);
      int        n;
      int        pos;
      out_item_t e;
      n = (length > MAX_KEPT) ? MAX_KEPT : length;
      if (it.opcode == OP_INSERT) begin
        inserts++;
        pos = n;
        // skip back over every entry that is not strictly better
        while (pos > 0 && !($signed(kept_score[pos-1]) > $signed(it.cand_score)))
          pos--;
        if (pos < n) begin
          for (int k = n - 1; k > pos; k--) begin
            kept_score[k] = kept_score[k-1];
            kept_seed[k]  = kept_seed[k-1];
          end
          kept_score[pos] = it.cand_score;
          kept_seed[pos]  = it.cand_seed;
        end
      end else begin
        dumps++;
        for (int k = 0; k < n; k++) begin
          e.rank      = RANK_W'(k);
          e.out_seed  = kept_seed[k];
          e.out_score = kept_score[k];
          e.last      = (k + 1 == n);
          due_entries.push_back(e);
        end
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_entries.size() == 0) begin
        $error("unexpected result: rank %0d seed %h score %0d last %0b",
               got.rank, got.out_seed, $signed(got.out_score), got.last);
        errors++;
        return;
      end
      want = due_entries.pop_front();
      entries_checked++;
      if (got.rank !== want.rank) begin
        $error("rank mismatch: expected %0d, actual %0d", want.rank, got.rank);
        errors++;
      end
      if (got.out_seed !== want.out_seed) begin
        $error("out_seed mismatch: expected %h, actual %h", want.out_seed, got.out_seed);
        errors++;
      end
      if (got.out_score !== want.out_score) begin
        $error("out_score mismatch: expected %0d, actual %0d",
               $signed(want.out_score), $signed(got.out_score));
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_item;

  ranked_list_model ranking;
  bit               calm = 1'b0;
  bit               hold_req = 1'b0;
  int unsigned      quiet_cycles = 0;

  top_k_score_tracker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Transaction monitor: everything sampled at the edge, before any update lands.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (cfg_valid && cfg_ready)
        ranking.set_length(cfg_data);
      if (in_valid && in_ready)
        ranking.note_input(in_item);
      if (out_valid && out_ready)
        ranking.check_result(out_item);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("top_k_score_tracker verification failed");
    $finish;
  end

  // Result sink: random back-pressure, or a long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 15);
      end
    end
  end

  function automatic in_item_t pack_item(op_e op, logic [DATA_W-1:0] seed,
                                         logic [DATA_W-1:0] score);
    in_item_t it;
    it.opcode     = op;
    it.cand_seed  = seed;
    it.cand_score = score;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.opcode = ($urandom_range(6) == 0) ? OP_DUMP : OP_INSERT;
    case ($urandom_range(7))
      0:       it.cand_seed = '0;
      1:       it.cand_seed = '1;
      default: it.cand_seed = $urandom;
    endcase
    // narrow ranges give plenty of ties, extremes hit the ends of the order
    case ($urandom_range(3))
      0: it.cand_score = $urandom_range(8) - 4;
      1: begin
        case ($urandom_range(3))
          0: it.cand_score = 32'h7fff_ffff;
          1: it.cand_score = 32'h8000_0000;
          2: it.cand_score = 32'h0000_0000;
          default: it.cand_score = 32'hffff_ffff;
        endcase
      end
      default: it.cand_score = $urandom;
    endcase
    return it;
  endfunction

  task automatic push_item(input in_item_t it);
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 40);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (ranking.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [CFG_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] len, input int count);
    write_length(len);
    for (int i = 0; i < count; i++)
      push_item(random_item());
    push_item(pack_item(OP_DUMP, $urandom, $urandom));
    drain();
  endtask

  initial begin
    ranking   = new();
    rst_ni    = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_item   = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset list of one zero entry; lower score ignored, equal score replaces
    push_item(pack_item(OP_DUMP, 32'h0, 32'h0));
    push_item(pack_item(OP_INSERT, 32'h1, 32'hffff_ffff));
    push_item(pack_item(OP_INSERT, 32'hffff_ffff, 32'h0));
    push_item(pack_item(OP_DUMP, 32'h0, 32'h0));
    drain();

    write_length(4);
    push_item(pack_item(OP_INSERT, 32'h0, 32'h7fff_ffff));
    push_item(pack_item(OP_INSERT, 32'h2, 32'h8000_0000));
    push_item(pack_item(OP_INSERT, 32'h3, 32'h0));
    push_item(pack_item(OP_INSERT, 32'h5, 32'h7));
    push_item(pack_item(OP_INSERT, 32'h6, 32'h7));
    push_item(pack_item(OP_DUMP, 32'hffff_ffff, 32'hffff_ffff));
    drain();

    // empty list: inserts do nothing, dump gives nothing
    write_length(0);
    push_item(pack_item(OP_INSERT, 32'h7, 32'h7fff_ffff));
    push_item(pack_item(OP_DUMP, 32'h0, 32'h0));
    drain();

    // oversized length acts as the full list; older storage reappears
    write_length(31);
    push_item(pack_item(OP_INSERT, 32'h8, 32'h8000_0000));
    push_item(pack_item(OP_INSERT, 32'h9, 32'h0));
    push_item(pack_item(OP_INSERT, 32'ha5a5_5a5a, 32'hffff_fffe));
    push_item(pack_item(OP_DUMP, 32'h0, 32'h0));
    drain();

    random_phase(16, 20);
    random_phase(1, 15);
    calm = 1'b1;
    random_phase(7, 40);
    calm = 1'b0;
    random_phase(0, 8);
    random_phase(17, 20);

    // long sink hold-off with a dump in flight so the input backs up
    write_length(16);
    hold_req = 1'b1;
    push_item(pack_item(OP_DUMP, 32'h0, 32'h0));
    for (int i = 0; i < 12; i++)
      push_item(random_item());
    push_item(pack_item(OP_DUMP, 32'h0, 32'h0));
    drain();

    random_phase(2, 15);
    random_phase(12, 20);
    random_phase(CFG_W'($urandom_range(31)), 20);
    random_phase(16, 20);

    $display("Run covered %0d inserts and %0d dumps over %0d length settings,",
             ranking.inserts, ranking.dumps, ranking.settings);
    $display("with %0d ranked entries compared against the predicted list.",
             ranking.entries_checked);
    if (ranking.errors == 0)
      $display("top_k_score_tracker verification clean");
    else
      $display("top_k_score_tracker verification failed");
    $finish;
  end

endmodule
